### sv/lpmc_pkg.sv
// lpmc_pkg: shared constants for the LRU page miss counter.
// Register indexes, configuration widths, reset values and output saturation limits.
// No dependencies.
package lpmc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int PSIZE_W    = 17;
    localparam int CAP_CFG_W  = 7;
    localparam int MISS_OUT_W = 31;
    localparam int HITS_OUT_W = 31;
    localparam int TOTAL_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CACHE_CAP = 2'd1;

    localparam logic [PSIZE_W-1:0]   PAGE_SIZE_RST = 17'd4096;
    localparam logic [CAP_CFG_W-1:0] CACHE_CAP_RST = 7'd64;

    localparam logic [63:0] MISS_OUT_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] TOTAL_MAX    = 64'h0000_0000_FFFF_FFFF;

endpackage

### sv/lpmc_ram.sv
// lpmc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpmc_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/lru_page_miss_counter.sv
// lru_page_miss_counter: page-range access counter against a fully associative LRU cache.
// Depends on lpmc_pkg (constants) and lpmc_ram (tag store).
//
//   channel   signals                                        flow
//   -------   --------------------------------------------   ----------------------
//   command   start, busy, start_offset, end_offset,         in, taken on start & !busy
//             first_access
//   result    done, misses_in_access, hits_in_access,        out, one-cycle strobe
//             total_misses
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data      in, valid & ready
//
// After the accepting edge the two page divisions run on one restoring divider, one
// quotient bit per cycle. Each page visited takes a check step, a read and a compare per
// tag (one RAM read port), a compaction entry step, a check, read and write per entry
// moved, and an append step. A run of pages past the cache contents takes setup steps
// and one write per refilled page (at most capacity). The finish step ends the
// transaction, done rising in the cycle after; a reversed range goes straight there.
// Reset clears occupancy, miss total and configuration; the tag RAM needs no clear.
// The result strobe cannot be stalled; busy stays high until it is issued.
module lru_page_miss_counter #(
    parameter int CACHE_ENTRIES = 64,
    parameter int OFFSET_BITS   = 31
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [OFFSET_BITS-1:0]            start_offset,
    input  logic [OFFSET_BITS-1:0]            end_offset,
    input  logic                              first_access,
    output logic                              done,
    output logic [lpmc_pkg::MISS_OUT_W-1:0]   misses_in_access,
    output logic [lpmc_pkg::HITS_OUT_W-1:0]   hits_in_access,
    output logic [lpmc_pkg::TOTAL_W-1:0]      total_misses,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lpmc_pkg::*;

    localparam int AW     = $clog2(CACHE_ENTRIES > 1 ? CACHE_ENTRIES : 2);
    localparam int OCC_W  = $clog2(CACHE_ENTRIES + 1);
    localparam int VIS_W  = OCC_W + 2;
    localparam int CNT_W  = OFFSET_BITS + 1;
    localparam int DCNT_W = $clog2(OFFSET_BITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_PG_CHECK, ST_SRCH_RD, ST_SRCH_CMP, ST_SH_CHK, ST_SH_RD,
        ST_SH_WR, ST_APPEND, ST_BULK, ST_BULK2, ST_BULK3, ST_BULK_WR, ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [PSIZE_W-1:0]     page_size_reg, page_size_next;
    logic [CAP_CFG_W-1:0]   cap_cfg_reg, cap_cfg_next;
    logic [OFFSET_BITS-1:0] e_reg, e_next;
    logic [OFFSET_BITS-1:0] dq_reg, dq_next;
    logic [PSIZE_W-1:0]     rem_reg, rem_next;
    logic [DCNT_W-1:0]      div_cnt_reg, div_cnt_next;
    logic                   div_pass_reg, div_pass_next;
    logic [CNT_W-1:0]       cur_reg, cur_next;
    logic [OFFSET_BITS-1:0] ep_reg, ep_next;
    logic [OCC_W-1:0]       occ_reg, occ_next;
    logic [VIS_W-1:0]       visited_reg, visited_next;
    logic [OCC_W-1:0]       idx_reg, idx_next;
    logic [OCC_W-1:0]       dst_reg, dst_next;
    logic [OCC_W-1:0]       drop_reg, drop_next;
    logic [CNT_W-1:0]       misses_reg, misses_next;
    logic [VIS_W-1:0]       hits_reg, hits_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]       r_reg, r_next;
    logic [OCC_W-1:0]       m_reg, m_next;
    logic [OFFSET_BITS-1:0] tag_reg, tag_next;
    logic                   is_hit_reg, is_hit_next;
    logic                   done_reg, done_next;
    logic [MISS_OUT_W-1:0]  miss_out_reg, miss_out_next;
    logic [HITS_OUT_W-1:0]  hits_out_reg, hits_out_next;

    // tag RAM ports
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [OFFSET_BITS-1:0] ram_wdata, ram_rdata;

    // combinational helpers
    logic [PSIZE_W-1:0]     ps_eff;
    logic [OCC_W-1:0]       cap_eff;
    logic [PSIZE_W:0]       rem_sh;
    logic                   q_bit;
    logic [OCC_W:0]         sh_src;
    logic [OCC_W+CNT_W:0]   occ_plus_r;
    logic [63:0]            total_sum;

    lpmc_ram #(
        .WIDTH(OFFSET_BITS),
        .DEPTH(CACHE_ENTRIES)
    ) u_tag_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign busy             = (state_reg != ST_IDLE);
    assign cfg_ready        = 1'b1;
    assign done             = done_reg;
    assign misses_in_access = miss_out_reg;
    assign hits_in_access   = hits_out_reg;
    assign total_misses     = total_reg;

    // effective page size and capacity
    always_comb
    begin
        ps_eff = (page_size_reg == '0) ? PSIZE_W'(1) : page_size_reg;
        if (cap_cfg_reg == '0)
        begin
            cap_eff = OCC_W'(1);
        end
        else if (32'(cap_cfg_reg) > 32'(CACHE_ENTRIES))
        begin
            cap_eff = OCC_W'(CACHE_ENTRIES);
        end
        else
        begin
            cap_eff = OCC_W'(cap_cfg_reg);
        end
    end

    // restoring divider step: one quotient bit a cycle
    always_comb
    begin
        rem_sh = {rem_reg, dq_reg[OFFSET_BITS-1]};
        q_bit  = (rem_sh >= {1'b0, ps_eff});
    end

    assign sh_src     = {1'b0, dst_reg} + {1'b0, drop_reg};
    assign occ_plus_r = (OCC_W+CNT_W+1)'(occ_reg) + (OCC_W+CNT_W+1)'(r_reg);
    assign total_sum  = 64'(total_reg) + 64'(misses_reg);

    always_comb
    begin
        state_next     = state_reg;
        page_size_next = page_size_reg;
        cap_cfg_next   = cap_cfg_reg;
        e_next         = e_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        div_pass_next  = div_pass_reg;
        cur_next       = cur_reg;
        ep_next        = ep_reg;
        occ_next       = occ_reg;
        visited_next   = visited_reg;
        idx_next       = idx_reg;
        dst_next       = dst_reg;
        drop_next      = drop_reg;
        misses_next    = misses_reg;
        hits_next      = hits_reg;
        total_next     = total_reg;
        r_next         = r_reg;
        m_next         = m_reg;
        tag_next       = tag_reg;
        is_hit_next    = is_hit_reg;
        done_next      = 1'b0;
        miss_out_next  = miss_out_reg;
        hits_out_next  = hits_out_reg;
        ram_we         = 1'b0;
        ram_waddr      = dst_reg[AW-1:0];
        ram_wdata      = ram_rdata;
        ram_raddr      = idx_reg[AW-1:0];

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_PAGE_SIZE)
            begin
                page_size_next = cfg_data[PSIZE_W-1:0];
            end
            else if (cfg_index == REG_CACHE_CAP)
            begin
                cap_cfg_next = cfg_data[CAP_CFG_W-1:0];
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    e_next       = end_offset;
                    dq_next      = start_offset;
                    rem_next     = '0;
                    div_cnt_next = '0;
                    div_pass_next = 1'b0;
                    misses_next  = '0;
                    hits_next    = '0;
                    visited_next = '0;
                    if (first_access)
                    begin
                        occ_next   = '0;
                        total_next = '0;
                    end
                    // reversed range visits no pages
                    state_next = (end_offset < start_offset) ? ST_FINISH : ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next     = q_bit ? PSIZE_W'(rem_sh - {1'b0, ps_eff})
                                     : PSIZE_W'(rem_sh);
                dq_next      = {dq_reg[OFFSET_BITS-2:0], q_bit};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCNT_W'(OFFSET_BITS - 1))
                begin
                    div_cnt_next = '0;
                    rem_next     = '0;
                    if (!div_pass_reg)
                    begin
                        cur_next      = CNT_W'({dq_reg[OFFSET_BITS-2:0], q_bit});
                        dq_next       = e_reg;
                        div_pass_next = 1'b1;
                    end
                    else
                    begin
                        ep_next    = {dq_reg[OFFSET_BITS-2:0], q_bit};
                        state_next = ST_PG_CHECK;
                    end
                end
            end

            ST_PG_CHECK:
            begin
                idx_next = '0;
                if (cur_reg > CNT_W'(ep_reg))
                begin
                    state_next = ST_FINISH;
                end
                else if (visited_reg >= VIS_W'(occ_reg) && occ_reg <= cap_eff)
                begin
                    // cache now holds only pages of this access
                    state_next = ST_BULK;
                end
                else if (occ_reg == '0)
                begin
                    is_hit_next = 1'b0;
                    dst_next    = '0;
                    drop_next   = '0;
                    state_next  = ST_SH_CHK;
                end
                else
                begin
                    state_next = ST_SRCH_RD;
                end
            end

            ST_SRCH_RD:
            begin
                ram_raddr  = idx_reg[AW-1:0];
                state_next = ST_SRCH_CMP;
            end

            ST_SRCH_CMP:
            begin
                if (ram_rdata == cur_reg[OFFSET_BITS-1:0])
                begin
                    is_hit_next = 1'b1;
                    dst_next    = idx_reg;
                    drop_next   = OCC_W'(1);
                    state_next  = ST_SH_CHK;
                end
                else if (idx_reg + 1'b1 == occ_reg)
                begin
                    // miss: evict least recent entries down to capacity - 1
                    is_hit_next = 1'b0;
                    dst_next    = '0;
                    drop_next   = (occ_reg >= cap_eff) ? OCC_W'(occ_reg - cap_eff + 1'b1)
                                                       : '0;
                    state_next  = ST_SH_CHK;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end

            ST_SH_CHK:
            begin
                if (drop_reg != '0 && sh_src < {1'b0, occ_reg})
                begin
                    state_next = ST_SH_RD;
                end
                else
                begin
                    occ_next   = occ_reg - drop_reg;
                    state_next = ST_APPEND;
                end
            end

            ST_SH_RD:
            begin
                ram_raddr  = sh_src[AW-1:0];
                state_next = ST_SH_WR;
            end

            ST_SH_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = dst_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                dst_next   = dst_reg + 1'b1;
                state_next = ST_SH_CHK;
            end

            ST_APPEND:
            begin
                ram_we       = 1'b1;
                ram_waddr    = occ_reg[AW-1:0];
                ram_wdata    = cur_reg[OFFSET_BITS-1:0];
                occ_next     = occ_reg + 1'b1;
                visited_next = visited_reg + 1'b1;
                cur_next     = cur_reg + 1'b1;
                if (is_hit_reg)
                begin
                    hits_next = hits_reg + 1'b1;
                end
                else
                begin
                    misses_next = misses_reg + 1'b1;
                end
                state_next = ST_PG_CHECK;
            end

            ST_BULK:
            begin
                r_next     = CNT_W'(ep_reg) - cur_reg + 1'b1;
                state_next = ST_BULK2;
            end

            ST_BULK2:
            begin
                misses_next = misses_reg + r_reg;
                m_next      = (occ_plus_r > (OCC_W+CNT_W+1)'(cap_eff)) ? cap_eff
                                                                        : OCC_W'(occ_plus_r);
                state_next  = ST_BULK3;
            end

            ST_BULK3:
            begin
                // refill with the last m pages, lowest first
                tag_next   = OFFSET_BITS'(CNT_W'(ep_reg) - CNT_W'(m_reg) + 1'b1);
                occ_next   = '0;
                state_next = ST_BULK_WR;
            end

            ST_BULK_WR:
            begin
                if (occ_reg == m_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = occ_reg[AW-1:0];
                    ram_wdata = tag_reg;
                    tag_next  = tag_reg + 1'b1;
                    occ_next  = occ_reg + 1'b1;
                end
            end

            ST_FINISH:
            begin
                total_next    = (total_sum > TOTAL_MAX) ? '1 : TOTAL_W'(total_sum);
                miss_out_next = (64'(misses_reg) > MISS_OUT_MAX) ? '1
                                                                 : MISS_OUT_W'(misses_reg);
                hits_out_next = HITS_OUT_W'(hits_reg);
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            page_size_reg <= PAGE_SIZE_RST;
            cap_cfg_reg   <= CACHE_CAP_RST;
            occ_reg       <= '0;
            total_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            page_size_reg <= page_size_next;
            cap_cfg_reg   <= cap_cfg_next;
            occ_reg       <= occ_next;
            total_reg     <= total_next;
            done_reg      <= done_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        e_reg        <= e_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        div_cnt_reg  <= div_cnt_next;
        div_pass_reg <= div_pass_next;
        cur_reg      <= cur_next;
        ep_reg       <= ep_next;
        visited_reg  <= visited_next;
        idx_reg      <= idx_next;
        dst_reg      <= dst_next;
        drop_reg     <= drop_next;
        misses_reg   <= misses_next;
        hits_reg     <= hits_next;
        r_reg        <= r_next;
        m_reg        <= m_next;
        tag_reg      <= tag_next;
        is_hit_reg   <= is_hit_next;
        miss_out_reg <= miss_out_next;
        hits_out_reg <= hits_out_next;
    end

    // occupancy never exceeds the tag store
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CACHE_ENTRIES))
        else $error("occupancy beyond cache entries");

    // an accepted transaction keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start");

    // result strobe comes only out of the finish step and lasts one cycle
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_FINISH && !busy))
        else $error("result strobe without finish");

    // a hit always drops exactly one entry before the append
    a_hit_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPEND && is_hit_reg) |-> $past(drop_reg) == OCC_W'(1))
        else $error("hit compaction did not drop one entry");

endmodule
